[sv/tile_id_compactor_defines.svh]
// Assertion macros for the tile id compactor checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TILE_ID_COMPACTOR_DEFINES_SVH
`define TILE_ID_COMPACTOR_DEFINES_SVH

// Concurrent assertion on clk, off while reset is held.
`define TIC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle forces a signal true in the next.
`define TIC_ASSERT_NEXT(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (sig)) \
		else $error(msg);

`endif

[sv/tic_pkg.sv]
// Shared types and constants of the tile id compactor.
// No dependencies.
package tic_pkg;

	localparam int TILE_W    = 12;
	localparam int CNT_W     = 13;
	localparam int SET_W     = 2;
	localparam int SETS_HW   = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 13;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_SCAN  = 2'd1,
		CMD_REMAP = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NEW    = 2'd1,
		ST_RANGE  = 2'd2,
		ST_UNSEEN = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SET0_BASE = 3'd0,
		REG_SET0_SIZE = 3'd1,
		REG_SET1_BASE = 3'd2,
		REG_SET1_SIZE = 3'd3,
		REG_SET2_BASE = 3'd4,
		REG_SET2_SIZE = 3'd5,
		REG_SET3_BASE = 3'd6,
		REG_SET3_SIZE = 3'd7
	} cfg_reg_t;

	// Result of the tileset range lookup
	typedef struct packed {
		logic             hit;
		logic [SET_W-1:0] idx;
	} set_match_t;

endpackage

[sv/tic_if.sv]
// Valid/ready channels of the tile id compactor: command beats in, result beats out.
// Depends on tic_pkg.
interface tic_req_if;
	logic                         valid;
	logic                         ready;
	tic_pkg::cmd_t                cmd;
	logic [tic_pkg::TILE_W-1:0]   tile_id;
	logic [tic_pkg::SET_W-1:0]    tileset_sel;
	logic [tic_pkg::TILE_W-1:0]   slot;

	modport source (output valid, cmd, tile_id, tileset_sel, slot, input ready);
	modport sink (input valid, cmd, tile_id, tileset_sel, slot, output ready);
endinterface

interface tic_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tic_pkg::TILE_W-1:0]   dense_id;
	logic [tic_pkg::TILE_W-1:0]   orig_tile;
	tic_pkg::status_t             status;
	logic [tic_pkg::CNT_W-1:0]    used_total;

	modport source (output valid, dense_id, orig_tile, status, used_total, input ready);
	modport sink (input valid, dense_id, orig_tile, status, used_total, output ready);
endinterface

[sv/tic_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/tic_cfg.sv]
// Tileset range registers and the first-match range lookup for a tile id.
// Depends on tic_pkg.
module tic_cfg #(
	parameter int NUM_TILESETS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tic_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tic_pkg::CFG_W-1:0]       cfg_data,
	input  logic [tic_pkg::TILE_W-1:0]      tile_id,
	output tic_pkg::set_match_t             match
);

	logic [tic_pkg::TILE_W-1:0] base_q [tic_pkg::SETS_HW];
	logic [tic_pkg::CNT_W-1:0]  size_q [tic_pkg::SETS_HW];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tic_pkg::SETS_HW; k++) begin
				base_q[k] <= '0;
				size_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (tic_pkg::cfg_reg_t'(cfg_idx))
				tic_pkg::REG_SET0_BASE: base_q[0] <= cfg_data[tic_pkg::TILE_W-1:0];
				tic_pkg::REG_SET0_SIZE: size_q[0] <= cfg_data;
				tic_pkg::REG_SET1_BASE: base_q[1] <= cfg_data[tic_pkg::TILE_W-1:0];
				tic_pkg::REG_SET1_SIZE: size_q[1] <= cfg_data;
				tic_pkg::REG_SET2_BASE: base_q[2] <= cfg_data[tic_pkg::TILE_W-1:0];
				tic_pkg::REG_SET2_SIZE: size_q[2] <= cfg_data;
				tic_pkg::REG_SET3_BASE: base_q[3] <= cfg_data[tic_pkg::TILE_W-1:0];
				tic_pkg::REG_SET3_SIZE: size_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// first enabled tileset whose range holds the id; lowest index wins
	// range end is one bit wider than a size so a large size cannot wrap
	always_comb begin
		match = '0;
		for (int k = NUM_TILESETS - 1; k >= 0; k--) begin
			if ((size_q[k] != '0) && (tile_id >= base_q[k]) &&
			    (((tic_pkg::CNT_W+1)'(base_q[k]) + (tic_pkg::CNT_W+1)'(size_q[k])) >
			     (tic_pkg::CNT_W+1)'(tile_id))) begin
				match.hit = 1'b1;
				match.idx = tic_pkg::SET_W'(k);
			end
		end
	end

endmodule

[sv/tile_id_compactor.sv]
// Tile id compactor top level: id dictionary and slot table RAMs, per-tileset counts.
// Depends on tic_pkg, tic_if, tic_ram, tic_cfg.
//
//   channel | dir | handshake     | beat
//   req     | in  | valid/ready   | cmd, tile_id, tileset_sel, slot
//   rsp     | out | valid/ready   | dense_id, orig_tile, status, used_total
//   cfg     | in  | cfg_we        | cfg_idx, cfg_data
//
// Scan, remap and read pass through stage 1 and the result register; one beat per
// cycle while rsp is ready and no clear runs. Both RAMs are read at accept and
// written when the item leaves stage 1; a one-entry bypass covers a read of the entry
// written in the same cycle. A clear walks all min(MAX_TILE_ID, 4096) dictionary entries
// (4096 by default) through its single write port, with req.ready low during the walk
// and while it holds stage 1. The same walk runs after reset. A stalled rsp holds the
// result register and the stage behind it.
module tile_id_compactor #(
	parameter int MAX_TILE_ID  = 4096,
	parameter int NUM_TILESETS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tic_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tic_pkg::CFG_W-1:0]       cfg_data,
	tic_req_if.sink                         req,
	tic_rsp_if.source                       rsp
);

	localparam int DICT_DEPTH = (MAX_TILE_ID < (1 << tic_pkg::TILE_W)) ?
	                            MAX_TILE_ID : (1 << tic_pkg::TILE_W);
	localparam int DICT_AW    = $clog2(DICT_DEPTH);
	localparam int DICT_W     = 1 + tic_pkg::SET_W + DICT_AW;
	localparam int SEL_W      = (NUM_TILESETS > 1) ? $clog2(NUM_TILESETS) : 1;
	localparam int SLOT_AW    = SEL_W + DICT_AW;
	localparam int SLOT_DEPTH = 1 << SLOT_AW;

	// handshake
	logic accept;
	logic s1_fire;

	// range lookup at accept
	tic_pkg::set_match_t match;

	// stage 1
	logic                        s1_valid_q;
	tic_pkg::cmd_t               cmd_s1;
	logic [tic_pkg::TILE_W-1:0]  id_s1;
	logic [tic_pkg::SET_W-1:0]   sel_s1;
	logic [tic_pkg::TILE_W-1:0]  slot_s1;
	tic_pkg::set_match_t         match_s1;
	logic                        id_ok_s1;
	logic                        dict_byp_s1;
	logic [DICT_W-1:0]           dict_byp_data_s1;
	logic                        slot_byp_s1;
	logic [tic_pkg::TILE_W-1:0]  slot_byp_data_s1;

	// memories
	logic                        dict_we;
	logic [DICT_AW-1:0]          dict_waddr;
	logic [DICT_W-1:0]           dict_wdata;
	logic [DICT_W-1:0]           dict_rdata;
	logic                        slot_we;
	logic [SLOT_AW-1:0]          slot_waddr;
	logic [SLOT_AW-1:0]          slot_raddr;
	logic [tic_pkg::TILE_W-1:0]  slot_rdata;

	// counters and clear pass
	logic [tic_pkg::CNT_W-1:0]   cnt_q [NUM_TILESETS];
	logic [tic_pkg::CNT_W-1:0]   total_q;
	logic                        clr_busy_q;
	logic [DICT_AW-1:0]          clr_ptr_q;

	// stage 1 results
	logic [DICT_W-1:0]           ent;
	logic                        ent_valid;
	logic [tic_pkg::SET_W-1:0]   ent_set;
	logic [DICT_AW-1:0]          ent_slot;
	logic [tic_pkg::TILE_W-1:0]  slot_word;
	logic [tic_pkg::SET_W-1:0]   cnt_idx;
	logic [tic_pkg::CNT_W-1:0]   cur_cnt;
	logic [tic_pkg::CNT_W-1:0]   dense_base;
	logic [tic_pkg::CNT_W-1:0]   pre_acc;
	logic [DICT_W-1:0]           new_ent;
	logic                        do_write;
	logic [tic_pkg::TILE_W-1:0]  dense_nx;
	logic [tic_pkg::TILE_W-1:0]  orig_nx;
	tic_pkg::status_t            status_nx;
	logic [tic_pkg::CNT_W-1:0]   total_nx;

	// output register
	logic                        rsp_valid_q;
	logic [tic_pkg::TILE_W-1:0]  dense_q;
	logic [tic_pkg::TILE_W-1:0]  orig_q;
	tic_pkg::status_t            status_q;
	logic [tic_pkg::CNT_W-1:0]   used_q;

	tic_cfg #(
		.NUM_TILESETS (NUM_TILESETS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.tile_id  (req.tile_id),
		.match    (match)
	);

	// flow control: no accept during a clear or its walk
	assign s1_fire   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !clr_busy_q && !(s1_valid_q && (cmd_s1 == tic_pkg::CMD_CLEAR)) &&
	                   (!s1_valid_q || s1_fire);
	assign accept    = req.valid && req.ready;

	// dictionary: per tile id {valid, tileset, local slot}
	assign dict_we    = clr_busy_q || (s1_fire && do_write);
	assign dict_waddr = clr_busy_q ? clr_ptr_q : id_s1[DICT_AW-1:0];
	assign dict_wdata = clr_busy_q ? '0 : new_ent;

	tic_ram #(
		.WIDTH (DICT_W),
		.DEPTH (DICT_DEPTH)
	) u_dict_ram (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (dict_wdata),
		.re    (accept),
		.raddr (req.tile_id[DICT_AW-1:0]),
		.rdata (dict_rdata)
	);

	// slot table: per {tileset, slot} the original id
	assign slot_we    = s1_fire && do_write;
	assign slot_waddr = {match_s1.idx[SEL_W-1:0], cur_cnt[DICT_AW-1:0]};
	assign slot_raddr = {req.tileset_sel[SEL_W-1:0], req.slot[DICT_AW-1:0]};

	tic_ram #(
		.WIDTH (tic_pkg::TILE_W),
		.DEPTH (SLOT_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (id_s1),
		.re    (accept),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload, bypass captured when the item ahead writes the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1           <= req.cmd;
			id_s1            <= req.tile_id;
			sel_s1           <= req.tileset_sel;
			slot_s1          <= req.slot;
			match_s1         <= match;
			id_ok_s1         <= (32'(req.tile_id) < MAX_TILE_ID);
			dict_byp_s1      <= s1_fire && do_write &&
			                    (req.tile_id[DICT_AW-1:0] == id_s1[DICT_AW-1:0]);
			dict_byp_data_s1 <= new_ent;
			slot_byp_s1      <= s1_fire && do_write && (slot_raddr == slot_waddr);
			slot_byp_data_s1 <= id_s1;
		end
	end

	// entry fields after bypass
	assign ent       = dict_byp_s1 ? dict_byp_data_s1 : dict_rdata;
	assign ent_valid = ent[DICT_W-1];
	assign ent_set   = ent[DICT_AW +: tic_pkg::SET_W];
	assign ent_slot  = ent[DICT_AW-1:0];
	assign slot_word = slot_byp_s1 ? slot_byp_data_s1 : slot_rdata;
	assign cnt_idx   = (cmd_s1 == tic_pkg::CMD_READ) ? sel_s1 : match_s1.idx;
	assign new_ent   = {1'b1, match_s1.idx, cur_cnt[DICT_AW-1:0]};

	// count of the addressed tileset and prefix sum of the tilesets before the entry's
	always_comb begin
		cur_cnt    = '0;
		dense_base = '0;
		pre_acc    = '0;
		for (int k = 0; k < NUM_TILESETS; k++) begin
			if (cnt_idx == tic_pkg::SET_W'(k)) begin
				cur_cnt = cnt_q[k];
			end
			if (ent_set == tic_pkg::SET_W'(k)) begin
				dense_base = pre_acc;
			end
			pre_acc = pre_acc + cnt_q[k];
		end
	end

	// command decode
	always_comb begin
		do_write  = 1'b0;
		dense_nx  = '0;
		orig_nx   = '0;
		status_nx = tic_pkg::ST_OK;
		case (cmd_s1)
			tic_pkg::CMD_CLEAR: begin
				status_nx = tic_pkg::ST_OK;
			end
			tic_pkg::CMD_SCAN: begin
				if (!(id_ok_s1 && match_s1.hit)) begin
					status_nx = tic_pkg::ST_RANGE;
				end else if (!ent_valid) begin
					do_write  = 1'b1;
					status_nx = tic_pkg::ST_NEW;
				end
			end
			tic_pkg::CMD_REMAP: begin
				if (!id_ok_s1) begin
					status_nx = tic_pkg::ST_RANGE;
				end else if (ent_valid) begin
					dense_nx = tic_pkg::TILE_W'(dense_base + tic_pkg::CNT_W'(ent_slot));
				end else begin
					status_nx = match_s1.hit ? tic_pkg::ST_UNSEEN : tic_pkg::ST_RANGE;
				end
			end
			tic_pkg::CMD_READ: begin
				if ((32'(sel_s1) >= NUM_TILESETS) ||
				    (tic_pkg::CNT_W'(slot_s1) >= cur_cnt)) begin
					status_nx = tic_pkg::ST_RANGE;
				end else begin
					orig_nx = slot_word;
				end
			end
			default: begin
				status_nx = tic_pkg::ST_OK;
			end
		endcase
	end

	assign total_nx = (cmd_s1 == tic_pkg::CMD_CLEAR) ? '0 :
	                  (total_q + tic_pkg::CNT_W'(do_write));

	// per-tileset counts and the running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TILESETS; k++) begin
				cnt_q[k] <= '0;
			end
			total_q <= '0;
		end else if (s1_fire) begin
			if (cmd_s1 == tic_pkg::CMD_CLEAR) begin
				for (int k = 0; k < NUM_TILESETS; k++) begin
					cnt_q[k] <= '0;
				end
			end else if (do_write) begin
				for (int k = 0; k < NUM_TILESETS; k++) begin
					if (match_s1.idx == tic_pkg::SET_W'(k)) begin
						cnt_q[k] <= cur_cnt + 1'b1;
					end
				end
			end
			total_q <= total_nx;
		end
	end

	// clear walk over the dictionary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_ptr_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_ptr_q == DICT_AW'(DICT_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
				clr_ptr_q  <= '0;
			end else begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
		end else if (s1_fire && (cmd_s1 == tic_pkg::CMD_CLEAR)) begin
			clr_busy_q <= 1'b1;
			clr_ptr_q  <= '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			dense_q  <= dense_nx;
			orig_q   <= orig_nx;
			status_q <= status_nx;
			used_q   <= total_nx;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.dense_id   = dense_q;
	assign rsp.orig_tile  = orig_q;
	assign rsp.status     = status_q;
	assign rsp.used_total = used_q;

endmodule

[sv/tic_checker.sv]
// Port-level checks of the tile id compactor, bound to the top level.
// Depends on tic_pkg and tile_id_compactor_defines.svh.
`include "tile_id_compactor_defines.svh"

module tic_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [tic_pkg::SET_W-1:0]      req_cmd,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [tic_pkg::TILE_W-1:0]     rsp_dense_id,
	input logic [tic_pkg::TILE_W-1:0]     rsp_orig_tile,
	input logic [1:0]                     rsp_status,
	input logic [tic_pkg::CNT_W-1:0]      rsp_used_total
);

	// a result beat stays until taken
	`TIC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped")

	// failed commands and newly added tiles carry no id
	`TIC_ASSERT(a_fail_zero, rsp_valid && (rsp_status != tic_pkg::ST_OK) |-> (rsp_dense_id == '0) && (rsp_orig_tile == '0), "nonzero id on failed command")

	// a newly added tile is counted
	`TIC_ASSERT(a_new_count, rsp_valid && (rsp_status == tic_pkg::ST_NEW) |-> (rsp_used_total != '0), "new tile not counted")

	// a beat is a remap or a read, never both
	`TIC_ASSERT(a_one_kind, rsp_valid && (rsp_dense_id != '0) |-> (rsp_orig_tile == '0), "dense and original id both set")

	// a clear stops intake for its dictionary walk
	`TIC_ASSERT_NEXT(a_clear_stall, req_valid && req_ready && (req_cmd == tic_pkg::CMD_CLEAR), !req_ready, "beat taken right after clear")

endmodule

bind tile_id_compactor tic_checker u_tic_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_cmd        (req.cmd),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_dense_id   (rsp.dense_id),
	.rsp_orig_tile  (rsp.orig_tile),
	.rsp_status     (rsp.status),
	.rsp_used_total (rsp.used_total)
);
